[sv/ofr_pkg.sv]
package ofr_pkg;

  localparam int SEQ_W = 5;
  localparam int GLYPH_COUNT = 44;
  localparam int INIT_LEN = 25;
  localparam logic [6:0] DEV_ADDR_RST = 7'd60;

  localparam logic [7:0] CTRL_CMD = 8'h00;
  localparam logic [7:0] CTRL_DATA = 8'h40;
  localparam logic [7:0] CMD_PAGE = 8'hB0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] COL_LO_MASK = 8'h0F;
  localparam logic [5:0] GLYPH_FALLBACK = 6'd42;

  typedef enum logic [2:0] {
    ACT_PIXEL  = 3'd0,
    ACT_GLYPH  = 3'd1,
    ACT_CLEAR  = 3'd2,
    ACT_BEGIN  = 3'd3,
    ACT_TICK   = 3'd4,
    ACT_STATUS = 3'd5,
    ACT_INIT   = 3'd6,
    ACT_NOP    = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    MODE_ADDR = 2'd0,
    MODE_DATA = 2'd1,
    MODE_INIT = 2'd2
  } mode_e;

  typedef struct packed {
    logic capture;
    logic pix_first;
    logic pix_rd;
    logic pix_wr;
    logic pix_next;
    logic clr_start;
    logic clr_step;
    logic emit_start;
    logic emit_load;
    logic data_rd;
    logic status_load;
    logic commit;
    logic begin_refresh;
    logic end_frame;
    logic init_reset;
  } cmd_t;

  typedef struct packed {
    action_e act;
    logic    pix_in_range;
    logic    pix_last;
    logic    clr_last;
    logic    emit_mem;
    logic    emit_last;
    logic    out_free;
    logic    tick_skip;
    logic    frame_done;
  } sts_t;

  localparam logic [7:0] INIT_CMDS [INIT_LEN] = '{
    8'hAE, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40,
    8'h8D, 8'h14, 8'h20, 8'h02, 8'hA1, 8'hC8, 8'hDA, 8'h12,
    8'h81, 8'h7F, 8'hD9, 8'hF1, 8'hDB, 8'h40, 8'hA4, 8'hA6, 8'hAF
  };

  localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][5] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
    '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00}, '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46},
    '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31}, '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
    '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39}, '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30},
    '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03}, '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E}, '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},
    '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41},
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01}, '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A},
    '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F}, '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
    '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01}, '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41},
    '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40}, '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F},
    '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F}, '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06}, '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E},
    '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46}, '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31},
    '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01}, '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F},
    '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F}, '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F},
    '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63}, '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07},
    '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}, '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
    '{8'h08, 8'h08, 8'h3E, 8'h08, 8'h08}, '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
    '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}, '{8'h62, 8'h64, 8'h08, 8'h13, 8'h23},
    '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06}, '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02}
  };

  function automatic logic [5:0] glyph_idx(logic [7:0] code);
    logic [5:0] idx;
    idx = GLYPH_FALLBACK;
    if (code >= 8'h30 && code <= 8'h39) begin
      idx = 6'(code - 8'h2F);
    end else if (code >= 8'h41 && code <= 8'h5A) begin
      idx = 6'(code - 8'h36);
    end else if (code == 8'h20) begin
      idx = 6'd0;
    end else if (code == 8'h3A) begin
      idx = 6'd37;
    end else if (code == 8'h2B) begin
      idx = 6'd38;
    end else if (code == 8'h2D) begin
      idx = 6'd39;
    end else if (code == 8'h2E) begin
      idx = 6'd40;
    end else if (code == 8'h25) begin
      idx = 6'd41;
    end else if (code == 8'h2F) begin
      idx = 6'd43;
    end
    return idx;
  endfunction

endpackage

[sv/ofr_ctrl.sv]
module ofr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ofr_pkg::sts_t sts_i,
  output ofr_pkg::cmd_t cmd_o
);
  import ofr_pkg::*;

  typedef enum logic [9:0] {
    ST_CLEAR    = 10'b0000000001,
    ST_IDLE     = 10'b0000000010,
    ST_DISPATCH = 10'b0000000100,
    ST_PIX_RD   = 10'b0000001000,
    ST_PIX_WR   = 10'b0000010000,
    ST_EMIT     = 10'b0000100000,
    ST_DATA_LD  = 10'b0001000000,
    ST_POST     = 10'b0010000000,
    ST_COMMIT   = 10'b0100000000,
    ST_STATUS   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = (sts_i.act == ACT_INIT) ? ST_COMMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_IDLE;
        unique case (sts_i.act)
          ACT_PIXEL, ACT_GLYPH: begin
            cmd_o.pix_first = 1'b1;
            state_d = ST_PIX_RD;
          end
          ACT_CLEAR: begin
            cmd_o.clr_start = 1'b1;
            state_d = ST_CLEAR;
          end
          ACT_BEGIN: cmd_o.begin_refresh = 1'b1;
          ACT_TICK: begin
            if (sts_i.tick_skip) begin
              state_d = ST_IDLE;
            end else if (sts_i.frame_done) begin
              cmd_o.end_frame = 1'b1;
            end else begin
              cmd_o.emit_start = 1'b1;
              state_d = ST_EMIT;
            end
          end
          ACT_STATUS: state_d = ST_STATUS;
          ACT_INIT: begin
            cmd_o.init_reset = 1'b1;
            cmd_o.emit_start = 1'b1;
            state_d = ST_EMIT;
          end
          ACT_NOP: state_d = ST_IDLE;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_PIX_RD: begin
        if (sts_i.pix_in_range) begin
          cmd_o.pix_rd = 1'b1;
          state_d = ST_PIX_WR;
        end else if (sts_i.pix_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.pix_next = 1'b1;
        end
      end
      ST_PIX_WR: begin
        cmd_o.pix_wr = 1'b1;
        if (sts_i.pix_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.pix_next = 1'b1;
          state_d = ST_PIX_RD;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          if (sts_i.emit_mem) begin
            cmd_o.data_rd = 1'b1;
            state_d = ST_DATA_LD;
          end else begin
            cmd_o.emit_load = 1'b1;
            if (sts_i.emit_last) begin
              state_d = ST_POST;
            end
          end
        end
      end
      ST_DATA_LD: begin
        cmd_o.emit_load = 1'b1;
        state_d = sts_i.emit_last ? ST_POST : ST_EMIT;
      end
      ST_POST: begin
        if (sts_i.act == ACT_INIT) begin
          cmd_o.clr_start = 1'b1;
          state_d = ST_CLEAR;
        end else begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = ST_IDLE;
      end
      ST_STATUS: begin
        if (sts_i.out_free) begin
          cmd_o.status_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[sv/ofr_datapath.sv]
module ofr_datapath #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64,
  parameter int CHUNK_BYTES  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ofr_pkg::cmd_t cmd_i,
  output ofr_pkg::sts_t sts_o,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i,
  input  logic [2:0]    action_i,
  input  logic [7:0]    x_pos_i,
  input  logic [7:0]    y_pos_i,
  input  logic          pixel_on_i,
  input  logic [7:0]    char_code_i,
  input  logic          bus_ok_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic          kind_o,
  output logic [7:0]    byte_out_o,
  output logic          last_o,
  output logic [6:0]    bus_address_o,
  output logic          idle_o,
  output logic          error_active_o,
  output logic [31:0]   failure_count_o,
  output logic          ready_res_o
);
  import ofr_pkg::*;

  localparam int NUM_PAGES = (PANEL_HEIGHT + 7) / 8;
  localparam int FB_BYTES  = PANEL_WIDTH * NUM_PAGES;
  localparam int AW        = $clog2(FB_BYTES);

  logic [7:0] mem [FB_BYTES];

  action_e     action_q;
  logic [7:0]  x_q, y_q, code_q;
  logic        on_q, ok_q;
  logic [6:0]  dev_q;
  logic [AW-1:0] clr_q;
  logic [2:0]  gc_q, gr_q;
  logic [7:0]  rd_q;
  mode_e       mode_q;
  logic [SEQ_W-1:0] k_q;
  logic [3:0]  page_q;
  logic [7:0]  col_q;
  logic        pend_q, busy_q, init_q, err_q;
  logic [31:0] fail_q;
  logic        out_valid_q, kind_q, last_q;
  logic [7:0]  byte_q;
  logic [6:0]  addr_q;
  logic        idle_q, erro_q, rdy_q;
  logic [31:0] cnt_q;

  logic        glyph;
  logic [7:0]  px, py, mask, col_sum, rem;
  logic        pix_bit;
  logic [AW-1:0] pix_addr, data_addr;
  logic [SEQ_W-1:0] chunk, kidx;
  logic [7:0]  fixed_byte;
  logic        out_free;

  assign glyph    = (action_q == ACT_GLYPH);
  assign px       = x_q + (glyph ? {5'd0, gc_q} : 8'd0);
  assign py       = y_q + (glyph ? {5'd0, gr_q} : 8'd0);
  assign pix_bit  = glyph ? GLYPH_ROM[glyph_idx(code_q)][gc_q][gr_q] : on_q;
  assign mask     = 8'd1 << py[2:0];
  assign pix_addr = AW'(px) + AW'(py[7:3]) * AW'(PANEL_WIDTH);

  assign rem      = 8'(PANEL_WIDTH) - col_q;
  assign chunk    = (rem < 8'(CHUNK_BYTES)) ? rem[SEQ_W-1:0] : SEQ_W'(CHUNK_BYTES);
  assign col_sum  = col_q + {{(8-SEQ_W){1'b0}}, chunk};
  assign kidx     = k_q - SEQ_W'(1);
  assign data_addr = AW'(page_q) * AW'(PANEL_WIDTH) + AW'(col_q) + AW'(kidx);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    fixed_byte = CTRL_CMD;
    unique case (mode_q)
      MODE_ADDR: begin
        unique case (k_q)
          SEQ_W'(0): fixed_byte = CTRL_CMD;
          SEQ_W'(1): fixed_byte = CMD_PAGE | {4'd0, page_q};
          SEQ_W'(2): fixed_byte = col_q & COL_LO_MASK;
          default:   fixed_byte = CMD_COL_HI | {4'd0, col_q[7:4]};
        endcase
      end
      MODE_DATA: fixed_byte = CTRL_DATA;
      MODE_INIT: fixed_byte = (k_q == '0) ? CTRL_CMD : INIT_CMDS[kidx];
      default:   fixed_byte = CTRL_CMD;
    endcase
  end

  always_comb begin
    sts_o.act          = action_q;
    sts_o.pix_in_range = (px < 8'(PANEL_WIDTH)) && (py < 8'(PANEL_HEIGHT));
    sts_o.pix_last     = !glyph || (gc_q == 3'd4 && gr_q == 3'd6);
    sts_o.clr_last     = (clr_q == AW'(FB_BYTES - 1));
    sts_o.emit_mem     = (mode_q == MODE_DATA) && (k_q != '0);
    unique case (mode_q)
      MODE_ADDR: sts_o.emit_last = (k_q == SEQ_W'(3));
      MODE_DATA: sts_o.emit_last = (k_q == chunk);
      MODE_INIT: sts_o.emit_last = (k_q == SEQ_W'(INIT_LEN));
      default:   sts_o.emit_last = 1'b1;
    endcase
    sts_o.out_free     = out_free;
    sts_o.tick_skip    = !init_q || !busy_q;
    sts_o.frame_done   = (page_q >= 4'(NUM_PAGES));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem[clr_q] <= 8'd0;
    end else if (cmd_i.pix_wr) begin
      mem[pix_addr] <= pix_bit ? (rd_q | mask) : (rd_q & ~mask);
    end
    if (cmd_i.data_rd) begin
      rd_q <= mem[data_addr];
    end else if (cmd_i.pix_rd) begin
      rd_q <= mem[pix_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q    <= x_pos_i;
      y_q    <= y_pos_i;
      on_q   <= pixel_on_i;
      code_q <= char_code_i;
      ok_q   <= bus_ok_i;
    end
    if (cmd_i.emit_start) begin
      if (action_q == ACT_INIT) begin
        mode_q <= MODE_INIT;
      end else begin
        mode_q <= pend_q ? MODE_ADDR : MODE_DATA;
      end
      k_q <= '0;
    end else if (cmd_i.emit_load) begin
      k_q <= k_q + SEQ_W'(1);
    end
    if (cmd_i.pix_first) begin
      gc_q <= 3'd0;
      gr_q <= 3'd0;
    end else if (cmd_i.pix_next) begin
      if (gr_q == 3'd6) begin
        gr_q <= 3'd0;
        gc_q <= gc_q + 3'd1;
      end else begin
        gr_q <= gr_q + 3'd1;
      end
    end
    if (cmd_i.emit_load) begin
      kind_q <= 1'b0;
      byte_q <= sts_o.emit_mem ? rd_q : fixed_byte;
      last_q <= sts_o.emit_last;
      addr_q <= dev_q;
      idle_q <= 1'b0;
      erro_q <= 1'b0;
      cnt_q  <= '0;
      rdy_q  <= 1'b0;
    end else if (cmd_i.status_load) begin
      kind_q <= 1'b1;
      byte_q <= 8'd0;
      last_q <= 1'b1;
      addr_q <= 7'd0;
      idle_q <= !busy_q;
      erro_q <= err_q;
      cnt_q  <= fail_q;
      rdy_q  <= init_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_q    <= ACT_CLEAR;
      dev_q       <= DEV_ADDR_RST;
      clr_q       <= '0;
      page_q      <= '0;
      col_q       <= '0;
      pend_q      <= 1'b0;
      busy_q      <= 1'b0;
      init_q      <= 1'b0;
      err_q       <= 1'b0;
      fail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dev_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        action_q <= action_e'(action_i);
      end
      if (cmd_i.clr_start) begin
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.emit_load || cmd_i.status_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.init_reset) begin
        page_q <= '0;
        col_q  <= '0;
        pend_q <= 1'b0;
        busy_q <= 1'b0;
        init_q <= 1'b0;
        err_q  <= 1'b0;
        fail_q <= '0;
      end else if (cmd_i.begin_refresh) begin
        if (init_q && !busy_q) begin
          page_q <= '0;
          col_q  <= '0;
          pend_q <= 1'b1;
          busy_q <= 1'b1;
        end
      end else if (cmd_i.end_frame) begin
        busy_q <= 1'b0;
        err_q  <= 1'b0;
      end else if (cmd_i.commit) begin
        if (!ok_q) begin
          fail_q <= fail_q + 32'd1;
          err_q  <= 1'b1;
          if (mode_q != MODE_INIT) begin
            busy_q <= 1'b0;
          end
        end else begin
          unique case (mode_q)
            MODE_INIT: begin
              init_q <= 1'b1;
              page_q <= '0;
              col_q  <= '0;
              pend_q <= 1'b1;
              busy_q <= 1'b1;
            end
            MODE_ADDR: pend_q <= 1'b0;
            MODE_DATA: begin
              if (col_sum >= 8'(PANEL_WIDTH)) begin
                page_q <= page_q + 4'd1;
                col_q  <= '0;
                pend_q <= 1'b1;
              end else begin
                col_q <= col_sum;
              end
            end
            default: pend_q <= pend_q;
          endcase
        end
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign byte_out_o      = byte_q;
  assign last_o          = last_q;
  assign bus_address_o   = addr_q;
  assign idle_o          = idle_q;
  assign error_active_o  = erro_q;
  assign failure_count_o = cnt_q;
  assign ready_res_o     = rdy_q;

endmodule

[sv/oled_framebuffer_refresh_core.sv]
// Page-organized monochrome framebuffer with panel refresh sequencing. Every emitted word
// passes through a one-word output register. After reset, and for every clear or init,
// the buffer is zeroed one byte per cycle (PANEL_WIDTH * pages bytes, 1024 by default)
// while no input is taken. Pixels and glyphs are drawn by read-modify-write on the
// single-port framebuffer. In a service tick, each data word is read from the memory
// into a register before it feeds the output register; init takes 26 words plus the
// clearing sweep.
module oled_framebuffer_refresh_core #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64,
  parameter int CHUNK_BYTES  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  x_pos_i,
  input  logic [7:0]  y_pos_i,
  input  logic        pixel_on_i,
  input  logic [7:0]  char_code_i,
  input  logic        bus_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  byte_out_o,
  output logic        last_o,
  output logic [6:0]  bus_address_o,
  output logic        idle_o,
  output logic        error_active_o,
  output logic [31:0] failure_count_o,
  output logic        ready_res_o
);
  import ofr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ofr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ofr_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .CHUNK_BYTES  (CHUNK_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (action_i),
    .x_pos_i         (x_pos_i),
    .y_pos_i         (y_pos_i),
    .pixel_on_i      (pixel_on_i),
    .char_code_i     (char_code_i),
    .bus_ok_i        (bus_ok_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .byte_out_o      (byte_out_o),
    .last_o          (last_o),
    .bus_address_o   (bus_address_o),
    .idle_o          (idle_o),
    .error_active_o  (error_active_o),
    .failure_count_o (failure_count_o),
    .ready_res_o     (ready_res_o)
  );

endmodule

[sv/ofr_checker.sv]
module ofr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        kind_o,
  input logic [7:0]  byte_out_o,
  input logic        last_o,
  input logic [6:0]  bus_address_o,
  input logic        idle_o,
  input logic        error_active_o,
  input logic [31:0] failure_count_o,
  input logic        ready_res_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_out_o))
    else $error("Output word dropped or changed while stalled.");

  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> last_o && byte_out_o == 8'd0 && bus_address_o == 7'd0)
    else $error("Status word carries transfer fields.");

  a_xfer_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> !idle_o && !error_active_o && failure_count_o == 32'd0
      && !ready_res_o)
    else $error("Transfer word carries status fields.");

  a_busy_needs_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> idle_o || ready_res_o)
    else $error("Refresh reported active before initialization.");

endmodule

bind oled_framebuffer_refresh_core ofr_checker u_chk (.*);
